// ===== rtl/rti_pkg.sv =====
// Shared constants and types for the ray/triangle intersection pipeline.
package rti_pkg;

    localparam int COORD_BITS      = 21;
    localparam int PARAM_FRAC_BITS = 24;
    localparam int POINT_BITS      = 63;
    localparam int TOL_BITS        = 25;
    localparam int TOL_FRAC_BITS   = 24;
    localparam int PARALLEL_LIMIT  = 1074;
    localparam int QUO_BITS        = 32;
    localparam int PARAM_BITS      = 32;

    typedef enum logic [1:0] {
        OC_HIT      = 2'd0,
        OC_PARALLEL = 2'd1,
        OC_OUT_U    = 2'd2,
        OC_OUT_VS   = 2'd3
    } t_outcome;

    // sideband that rides along the divider stages
    typedef struct packed {
        t_outcome outcome;
        logic     neg;
        logic     ovf;
    } t_div_tag;

endpackage

// ===== rtl/ray_triangle_intersect_top.sv =====
// Top level of the pipelined ray segment / triangle intersection test.
//
// Input channel: i_in_valid / o_in_stall with the segment end points and
// the three triangle corners; a beat is taken when valid is high and stall
// is low. Output channel: o_out_valid / i_out_stall with the hit parameter
// (signed Q7.24, zero unless the outcome is a hit) and the outcome code.
// Configuration: i_cfg_valid / o_cfg_ready carries the edge tolerance; the
// port is always ready. Write it only while the pipe is empty.
//
// Between input beat and output beat lie 8 arithmetic stages (differences,
// cross products, split dot products, sign fix, tolerance scaling, edge
// tests), 32 divider stages at one quotient bit each, a rounding stage and
// the output register. Throughput is one beat per cycle while not stalled.
//
// Reset clears all valid bits and the tolerance register. When the receiver
// stalls with a result waiting, the whole pipe holds and o_in_stall rises
// in the same cycle; nothing is dropped or repeated.
module ray_triangle_intersect_top #(
    parameter int COORD_BITS      = rti_pkg::COORD_BITS,
    parameter int PARAM_FRAC_BITS = rti_pkg::PARAM_FRAC_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [rti_pkg::POINT_BITS-1:0]   i_ray_start,
    input  logic [rti_pkg::POINT_BITS-1:0]   i_ray_end,
    input  logic [rti_pkg::POINT_BITS-1:0]   i_vertex_first,
    input  logic [rti_pkg::POINT_BITS-1:0]   i_vertex_second,
    input  logic [rti_pkg::POINT_BITS-1:0]   i_vertex_third,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic signed [rti_pkg::PARAM_BITS-1:0] o_hit_param,
    output logic [1:0]                       o_outcome,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [rti_pkg::TOL_BITS-1:0]     i_cfg_data
);

    localparam int CW  = COORD_BITS + 1;          // coordinate difference
    localparam int XW  = 2 * CW + 1;              // cross product
    localparam int XL  = (XW + 1) / 2;            // low split of cross term
    localparam int XH  = XW - XL;
    localparam int PLW = CW + XL + 1;
    localparam int PHW = CW + XH;
    localparam int DW  = CW + XW + 2;             // dot product, signed
    localparam int AW  = DW - 1;                  // magnitude
    localparam int CK  = (AW + 2) / 3;            // chunk for tolerance multiply
    localparam int TB  = rti_pkg::TOL_BITS;
    localparam int TF  = rti_pkg::TOL_FRAC_BITS;
    localparam int SW  = AW + TB;                 // slack
    localparam int TW  = DW + TF + 4;             // edge test width
    localparam int QB  = rti_pkg::QUO_BITS;
    localparam int GW  = AW + PARAM_FRAC_BITS + QB + 1;
    localparam int PB  = rti_pkg::PARAM_BITS;

    logic en;
    logic [7:0] r_vld;
    logic [TB-1:0] r_tol;

    assign en          = !(o_out_valid && i_out_stall);
    assign o_in_stall  = o_out_valid && i_out_stall;
    assign o_cfg_ready = 1'b1;

    // tolerance register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= '0;
        end else if (i_cfg_valid) begin
            r_tol <= i_cfg_data;
        end
    end

    // valid bits of the arithmetic stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[6:0], i_in_valid};
        end
    end

    function automatic logic signed [CW-1:0] crd(input logic [rti_pkg::POINT_BITS-1:0] w,
                                                 input int i);
        crd = CW'(signed'(w[i*COORD_BITS +: COORD_BITS]));
    endfunction

    // stage 1: coordinate differences
    logic signed [CW-1:0] r1_d [3], r1_e1 [3], r1_e2 [3], r1_s [3];
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r1_d[i]  <= crd(i_ray_end, i) - crd(i_ray_start, i);
                r1_e1[i] <= crd(i_vertex_second, i) - crd(i_vertex_first, i);
                r1_e2[i] <= crd(i_vertex_third, i) - crd(i_vertex_first, i);
                r1_s[i]  <= crd(i_ray_start, i) - crd(i_vertex_first, i);
            end
        end
    end

    // stage 2: cross product terms, q = d x e2, r = s x e1
    logic signed [2*CW-1:0] r2_pq [6], r2_pr [6];
    logic signed [CW-1:0] r2_d [3], r2_e1 [3], r2_e2 [3], r2_s [3];
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int j = 0; j < 3; j++) begin
                r2_pq[2*j]   <= r1_d[(j+1)%3] * r1_e2[(j+2)%3];
                r2_pq[2*j+1] <= r1_d[(j+2)%3] * r1_e2[(j+1)%3];
                r2_pr[2*j]   <= r1_s[(j+1)%3] * r1_e1[(j+2)%3];
                r2_pr[2*j+1] <= r1_s[(j+2)%3] * r1_e1[(j+1)%3];
            end
            r2_d  <= r1_d;
            r2_e1 <= r1_e1;
            r2_e2 <= r1_e2;
            r2_s  <= r1_s;
        end
    end

    // stage 3: cross products
    logic signed [XW-1:0] r3_q [3], r3_r [3];
    logic signed [CW-1:0] r3_d [3], r3_e1 [3], r3_e2 [3], r3_s [3];
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int j = 0; j < 3; j++) begin
                r3_q[j] <= XW'(r2_pq[2*j]) - XW'(r2_pq[2*j+1]);
                r3_r[j] <= XW'(r2_pr[2*j]) - XW'(r2_pr[2*j+1]);
            end
            r3_d  <= r2_d;
            r3_e1 <= r2_e1;
            r3_e2 <= r2_e2;
            r3_s  <= r2_s;
        end
    end

    // stage 4: split partial products of A = e1.q, U = s.q, V = d.r, W = e2.r
    logic signed [PLW-1:0] r4_plo [4][3];
    logic signed [PHW-1:0] r4_phi [4][3];
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r4_plo[0][i] <= r3_e1[i] * signed'({1'b0, r3_q[i][XL-1:0]});
                r4_phi[0][i] <= r3_e1[i] * signed'(r3_q[i][XW-1:XL]);
                r4_plo[1][i] <= r3_s[i]  * signed'({1'b0, r3_q[i][XL-1:0]});
                r4_phi[1][i] <= r3_s[i]  * signed'(r3_q[i][XW-1:XL]);
                r4_plo[2][i] <= r3_d[i]  * signed'({1'b0, r3_r[i][XL-1:0]});
                r4_phi[2][i] <= r3_d[i]  * signed'(r3_r[i][XW-1:XL]);
                r4_plo[3][i] <= r3_e2[i] * signed'({1'b0, r3_r[i][XL-1:0]});
                r4_phi[3][i] <= r3_e2[i] * signed'(r3_r[i][XW-1:XL]);
            end
        end
    end

    // stage 5: dot products
    logic signed [DW-1:0] r5_dot [4];
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 4; k++) begin
                r5_dot[k] <= DW'(r4_plo[k][0]) + DW'(r4_plo[k][1]) + DW'(r4_plo[k][2])
                           + (DW'(r4_phi[k][0]) <<< XL) + (DW'(r4_phi[k][1]) <<< XL)
                           + (DW'(r4_phi[k][2]) <<< XL);
            end
        end
    end

    // stage 6: make A positive, parallel check, tolerance partial products
    logic signed [DW-1:0] n6_dot [4];
    logic [3*CK-1:0]      n6_aext;
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            n6_dot[k] = r5_dot[0][DW-1] ? -r5_dot[k] : r5_dot[k];
        end
        n6_aext = (3*CK)'(n6_dot[0][AW-1:0]);
    end

    logic [AW-1:0]        r6_a;
    logic signed [DW-1:0] r6_u, r6_v, r6_w;
    logic                 r6_par;
    logic [CK+TB-1:0]     r6_sp [3];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_a   <= n6_dot[0][AW-1:0];
            r6_u   <= n6_dot[1];
            r6_v   <= n6_dot[2];
            r6_w   <= n6_dot[3];
            r6_par <= (n6_dot[0][AW-1:0] < AW'(rti_pkg::PARALLEL_LIMIT));
            for (int c = 0; c < 3; c++) begin
                r6_sp[c] <= n6_aext[c*CK +: CK] * r_tol;
            end
        end
    end

    // stage 7: slack = |A| * tolerance, magnitude of W
    logic [AW-1:0]        r7_a;
    logic signed [DW-1:0] r7_u, r7_v;
    logic [AW-1:0]        r7_wabs;
    logic                 r7_wneg;
    logic                 r7_par;
    logic [SW-1:0]        r7_slack;
    logic signed [DW-1:0] n7_wabs;
    assign n7_wabs = r6_w[DW-1] ? -r6_w : r6_w;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r7_a     <= r6_a;
            r7_u     <= r6_u;
            r7_v     <= r6_v;
            r7_wabs  <= n7_wabs[AW-1:0];
            r7_wneg  <= r6_w[DW-1];
            r7_par   <= r6_par;
            r7_slack <= SW'(r6_sp[0]) + (SW'(r6_sp[1]) << CK) + (SW'(r6_sp[2]) << (2*CK));
        end
    end

    // stage 8: edge tests and divider setup
    logic signed [TW-1:0] t_u, t_v, t_a, t_s, t_c2, t_c3, t_sum;
    logic                 c2, c3;
    logic [GW-1:0]        g_num, g_den;
    rti_pkg::t_div_tag    n8_tag;
    always_comb begin
        t_u   = TW'(r7_u);
        t_v   = TW'(r7_v);
        t_a   = TW'(r7_a);
        t_s   = TW'(r7_slack);
        t_c2  = (t_u <<< TF) + t_s;
        t_c3  = (t_v <<< TF) + t_s;
        t_sum = ((t_u + t_v) <<< TF) - (t_a <<< TF) - t_s;
        c2    = t_c2[TW-1];
        c3    = t_c3[TW-1] || (!t_sum[TW-1] && (t_sum != '0));
        g_num = GW'(r7_wabs) << PARAM_FRAC_BITS;
        g_den = GW'(r7_a) << QB;
        n8_tag.neg = r7_wneg;
        n8_tag.ovf = (g_num >= g_den);
        if (r7_par) begin
            n8_tag.outcome = rti_pkg::OC_PARALLEL;
        end else if (c2) begin
            n8_tag.outcome = rti_pkg::OC_OUT_U;
        end else if (c3) begin
            n8_tag.outcome = rti_pkg::OC_OUT_VS;
        end else begin
            n8_tag.outcome = rti_pkg::OC_HIT;
        end
    end

    logic [AW-1:0]     r8_rem;
    logic [QB-1:0]     r8_low;
    logic [AW-1:0]     r8_den;
    rti_pkg::t_div_tag r8_tag;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r8_rem <= AW'(g_num >> QB);
            r8_low <= g_num[QB-1:0];
            r8_den <= r7_a;
            r8_tag <= n8_tag;
        end
    end

    // divider: |W| * 2^frac / |A|, rounded
    logic              div_valid;
    logic [QB:0]       div_quo;
    rti_pkg::t_div_tag div_tag;

    rti_div #(
        .AW (AW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_vld[7]),
        .i_rem   (r8_rem),
        .i_low   (r8_low),
        .i_den   (r8_den),
        .i_tag   (r8_tag),
        .o_valid (div_valid),
        .o_quo   (div_quo),
        .o_tag   (div_tag)
    );

    // output register: sign, saturation, zero on a miss
    logic signed [PB-1:0] n_param;
    logic signed [PB-1:0] r_param;
    logic [1:0]           r_outcome;
    logic                 r_out_valid;
    always_comb begin
        if (div_tag.outcome != rti_pkg::OC_HIT) begin
            n_param = '0;
        end else if (div_tag.neg) begin
            if (div_tag.ovf || (div_quo > (QB+1)'(33'h080000000))) begin
                n_param = {1'b1, {(PB-1){1'b0}}};
            end else begin
                n_param = -signed'(div_quo[PB-1:0]);
            end
        end else begin
            if (div_tag.ovf || (div_quo > (QB+1)'(33'h07FFFFFFF))) begin
                n_param = {1'b0, {(PB-1){1'b1}}};
            end else begin
                n_param = signed'(div_quo[PB-1:0]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= div_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_param   <= n_param;
            r_outcome <= div_tag.outcome;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_hit_param = r_param;
    assign o_outcome   = r_outcome;

    // checks
    a_miss_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_outcome != rti_pkg::OC_HIT)) |-> (o_hit_param == '0))
        else $error("miss outcome with nonzero parameter");

    a_stall_only_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with empty output register");

    a_reset_empty : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

endmodule

// ===== rtl/rti_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with rounding stage.
module rti_div #(
    parameter int AW = 68
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [AW-1:0]                 i_rem,
    input  logic [rti_pkg::QUO_BITS-1:0]  i_low,
    input  logic [AW-1:0]                 i_den,
    input  rti_pkg::t_div_tag             i_tag,
    output logic                          o_valid,
    output logic [rti_pkg::QUO_BITS:0]    o_quo,
    output rti_pkg::t_div_tag             o_tag
);

    localparam int QB = rti_pkg::QUO_BITS;

    logic [AW-1:0]     r_rem [QB];
    logic [QB-1:0]     r_low [QB];
    logic [QB-1:0]     r_quo [QB];
    logic [AW-1:0]     r_den [QB];
    rti_pkg::t_div_tag r_tag [QB];
    logic [QB-1:0]     r_vld;

    logic [QB:0]       r_qr;
    rti_pkg::t_div_tag r_tag_o;
    logic              r_vld_o;

    genvar k;
    generate
        for (k = 0; k < QB; k++) begin : g_stage
            logic [AW-1:0]     rin;
            logic [QB-1:0]     lin;
            logic [QB-1:0]     qin;
            logic [AW-1:0]     din;
            rti_pkg::t_div_tag tin;
            logic              vin;
            logic [AW:0]       sh;
            logic              ge;

            if (k == 0) begin : g_first
                assign rin = i_rem;
                assign lin = i_low;
                assign qin = '0;
                assign din = i_den;
                assign tin = i_tag;
                assign vin = i_valid;
            end else begin : g_next
                assign rin = r_rem[k-1];
                assign lin = r_low[k-1];
                assign qin = r_quo[k-1];
                assign din = r_den[k-1];
                assign tin = r_tag[k-1];
                assign vin = r_vld[k-1];
            end

            // trial subtract of the shifted partial remainder
            assign sh = {rin, lin[QB-1]};
            assign ge = (sh >= {1'b0, din});

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[k] <= 1'b0;
                end else if (i_en) begin
                    r_vld[k] <= vin;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= ge ? AW'(sh - {1'b0, din}) : AW'(sh);
                    r_low[k] <= {lin[QB-2:0], 1'b0};
                    r_quo[k] <= {qin[QB-2:0], ge};
                    r_den[k] <= din;
                    r_tag[k] <= tin;
                end
            end
        end
    endgenerate

    // round to nearest, ties away from zero
    logic rnd;
    assign rnd = ({r_rem[QB-1], 1'b0} >= {1'b0, r_den[QB-1]});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_o <= 1'b0;
        end else if (i_en) begin
            r_vld_o <= r_vld[QB-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_qr    <= {1'b0, r_quo[QB-1]} + {{QB{1'b0}}, rnd};
            r_tag_o <= r_tag[QB-1];
        end
    end

    assign o_valid = r_vld_o;
    assign o_quo   = r_qr;
    assign o_tag   = r_tag_o;

endmodule
